FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define WSJD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define WSJD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/wsjd_pkg.sv
// ----------------------------------------------------------------------------
// wsjd_pkg
// Types, codes and default sizes for the work-stealing job dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wsjd_pkg;

  localparam int NUM_WORKERS_DEF  = 8;
  localparam int LOCAL_DEPTH_DEF  = 16;
  localparam int GLOBAL_DEPTH_DEF = 64;

  // Field widths fixed by the port list
  localparam int TAG_BITS      = 16;
  localparam int CMD_BITS      = 2;
  localparam int WID_BITS      = 3;
  localparam int VICTIM_BITS   = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 4;
  localparam int ACT_BITS      = 4;

  localparam logic [ACT_BITS-1:0] ACTIVE_RESET = 4'd4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_WORKERS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLED        = 2'd1;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_SUBMIT_GLOBAL = 2'd0,
    CMD_SUBMIT_WORKER = 2'd1,
    CMD_FETCH         = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    SRC_NONE   = 2'd0,
    SRC_OWN    = 2'd1,
    SRC_GLOBAL = 2'd2,
    SRC_STOLEN = 2'd3
  } src_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_REDIRECT   = 3'd1,
    ST_FULL       = 3'd2,
    ST_DISABLED   = 3'd3,
    ST_BAD_WORKER = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_META  = 2'd1,
    S_LDATA = 2'd2,
    S_GDATA = 2'd3
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/wsjd_tag_ram.sv
// ----------------------------------------------------------------------------
// wsjd_tag_ram
// Simple dual-port tag store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wsjd_tag_ram import wsjd_pkg::*; #(
  parameter int DEPTH = GLOBAL_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire logic [TAG_BITS-1:0] wdata,
  input  wire logic                re,
  input  wire logic [AW-1:0]       raddr,
  output logic      [TAG_BITS-1:0] rdata
);

  logic [TAG_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/wsjd_meta_ram.sv
// ----------------------------------------------------------------------------
// wsjd_meta_ram
// Per-worker queue head and count; entries never written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wsjd_meta_ram import wsjd_pkg::*; #(
  parameter int NUM_WORKERS = NUM_WORKERS_DEF,
  parameter int LOCAL_DEPTH = LOCAL_DEPTH_DEF,
  parameter int WW          = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1,
  parameter int HW          = $clog2(LOCAL_DEPTH),
  parameter int CW          = $clog2(LOCAL_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          re,
  input  wire logic [WW-1:0] raddr,
  input  wire logic          we,
  input  wire logic [WW-1:0] waddr,
  input  wire logic [HW-1:0] whead,
  input  wire logic [CW-1:0] wcount,
  output logic      [HW-1:0] rhead,
  output logic      [CW-1:0] rcount
);

  logic [HW+CW-1:0]      mem [NUM_WORKERS];
  logic [NUM_WORKERS-1:0] valid_r;
  logic [HW+CW-1:0]      rdata_r;
  logic                  rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {whead, wcount};
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (re) begin
        rvalid_r <= valid_r[raddr];
      end
    end
  end

  assign rhead  = rvalid_r ? rdata_r[HW+CW-1:CW] : '0;
  assign rcount = rvalid_r ? rdata_r[CW-1:0]     : '0;

endmodule

`default_nettype wire

FILE: rtl/wsjd_steal_pick.sv
// ----------------------------------------------------------------------------
// wsjd_steal_pick
// Rotating victim search: first non-empty active worker after the requester.
// ----------------------------------------------------------------------------
`default_nettype none

module wsjd_steal_pick import wsjd_pkg::*; #(
  parameter int NUM_WORKERS = NUM_WORKERS_DEF,
  parameter int WW          = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1,
  parameter int NB          = $clog2(NUM_WORKERS + 1)
) (
  input  wire logic [NUM_WORKERS-1:0] nonempty,
  input  wire logic [NB-1:0]          n_active,
  input  wire logic [WW-1:0]          requester,
  output logic                        found,
  output logic      [WW-1:0]          victim
);

  logic [31:0]            start;
  logic [NUM_WORKERS-1:0] cand;
  logic [NUM_WORKERS-1:0] upper;
  logic [NUM_WORKERS-1:0] sel;
  logic [NUM_WORKERS-1:0] lowest;

  // scan begins just past the requester, wrapping at the active count
  assign start = (32'(requester) + 32'd1 == 32'(n_active)) ? 32'd0
                                                           : 32'(requester) + 32'd1;

  always_comb begin
    for (int v = 0; v < NUM_WORKERS; v++) begin
      cand[v]  = nonempty[v] && (32'(v) < 32'(n_active)) && (32'(v) != 32'(requester));
      upper[v] = cand[v] && (32'(v) >= start);
    end
  end

  assign sel    = (upper != '0) ? upper : cand;
  assign lowest = sel & (~sel + NUM_WORKERS'(1));
  assign found  = (cand != '0);

  always_comb begin
    victim = '0;
    for (int v = 0; v < NUM_WORKERS; v++) begin
      if (lowest[v]) begin
        victim = victim | WW'(v);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/work_stealing_job_dispatcher.sv
// Result strobe: registered in the cycle after start for rejects, global submits and empty
//   fetches; worker submits go through S_META, global fetches through S_GDATA, and own-queue
//   and stolen fetches through S_META and S_LDATA. One item at a time: busy covers the whole
//   read-modify-write, the per-worker head/count memory read followed by the tag memory read.
// Reset: queues empty, 4 active workers, enabled; queue memories need no clearing pass.
// ----------------------------------------------------------------------------
// work_stealing_job_dispatcher
// Job-tag dispatcher with a global FIFO and one local FIFO per worker,
// fetching from own queue, then global, then stealing by rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module work_stealing_job_dispatcher import wsjd_pkg::*; #(
  parameter int NUM_WORKERS  = NUM_WORKERS_DEF,
  parameter int LOCAL_DEPTH  = LOCAL_DEPTH_DEF,
  parameter int GLOBAL_DEPTH = GLOBAL_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [CMD_BITS-1:0]      in_cmd,
  input  wire logic [WID_BITS-1:0]      in_worker_id,
  input  wire logic [TAG_BITS-1:0]      in_job_tag,
  output logic                          out_valid,
  output logic      [TAG_BITS-1:0]      out_job_out,
  output logic                          out_got_job,
  output logic      [1:0]               out_source,
  output logic      [VICTIM_BITS-1:0]   out_victim,
  output logic      [2:0]               out_status,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int WW  = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int NB  = $clog2(NUM_WORKERS + 1);
  localparam int LA  = $clog2(LOCAL_DEPTH);
  localparam int LCW = $clog2(LOCAL_DEPTH + 1);
  localparam int GA  = $clog2(GLOBAL_DEPTH);
  localparam int GCW = $clog2(GLOBAL_DEPTH + 1);
  localparam int SD  = NUM_WORKERS * LOCAL_DEPTH;
  localparam int SA  = (SD > 1) ? $clog2(SD) : 1;

  // configuration
  logic [ACT_BITS-1:0] act_r;
  logic                en_r;
  logic [NB-1:0]       n_active;

  // control and queue state
  state_t                 state_r, state_nxt;
  logic [NUM_WORKERS-1:0] nonempty_r, nonempty_nxt;
  logic [GA-1:0]          gh_r, gh_nxt;
  logic [GCW-1:0]         gc_r, gc_nxt;
  logic [WW-1:0]          tgt_r, tgt_nxt;
  logic                   push_r, push_nxt;
  src_t                   src_r, src_nxt;
  logic [TAG_BITS-1:0]    tag_r, tag_nxt;

  // result registers
  logic                   out_valid_r, out_valid_nxt;
  logic [TAG_BITS-1:0]    job_r, job_nxt;
  logic                   got_r, got_nxt;
  src_t                   osrc_r, osrc_nxt;
  logic [VICTIM_BITS-1:0] vic_r, vic_nxt;
  status_t                st_r, st_nxt;

  // memory ports
  logic                g_we, g_re;
  logic [GA-1:0]       g_waddr, g_raddr;
  logic [TAG_BITS-1:0] g_rdata;
  logic                l_we, l_re;
  logic [SA-1:0]       l_waddr, l_raddr;
  logic [TAG_BITS-1:0] l_rdata;
  logic                m_re, m_we;
  logic [WW-1:0]       m_raddr;
  logic [LA-1:0]       m_whead, m_rhead;
  logic [LCW-1:0]      m_wcount, m_rcount;

  logic          accept;
  logic          w_ok;
  logic [WW-1:0] w_idx;
  logic          steal_found;
  logic [WW-1:0] steal_victim;
  logic [31:0]   gsum, lsum;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign n_active = (act_r == '0) ? NB'(1) :
                    (32'(act_r) > 32'(NUM_WORKERS)) ? NB'(NUM_WORKERS) : NB'(act_r);
  assign w_ok  = (32'(in_worker_id) < 32'(n_active));
  assign w_idx = WW'(in_worker_id);

  assign gsum = 32'(gh_r) + 32'(gc_r);
  assign lsum = 32'(m_rhead) + 32'(m_rcount);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= ACTIVE_RESET;
      en_r  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACTIVE_WORKERS: act_r <= cfg_data[ACT_BITS-1:0];
        CFG_ENABLED:        en_r  <= cfg_data[0];
        default:            ;
      endcase
    end
  end

  wsjd_steal_pick #(
    .NUM_WORKERS (NUM_WORKERS),
    .WW          (WW),
    .NB          (NB)
  ) u_pick (
    .nonempty  (nonempty_r),
    .n_active  (n_active),
    .requester (w_idx),
    .found     (steal_found),
    .victim    (steal_victim)
  );

  wsjd_tag_ram #(
    .DEPTH (GLOBAL_DEPTH),
    .AW    (GA)
  ) u_global_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (in_job_tag),
    .re    (g_re),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  wsjd_tag_ram #(
    .DEPTH (SD),
    .AW    (SA)
  ) u_local_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (tag_r),
    .re    (l_re),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  wsjd_meta_ram #(
    .NUM_WORKERS (NUM_WORKERS),
    .LOCAL_DEPTH (LOCAL_DEPTH),
    .WW          (WW),
    .HW          (LA),
    .CW          (LCW)
  ) u_meta_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .re     (m_re),
    .raddr  (m_raddr),
    .we     (m_we),
    .waddr  (tgt_r),
    .whead  (m_whead),
    .wcount (m_wcount),
    .rhead  (m_rhead),
    .rcount (m_rcount)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nonempty_r  <= '0;
      gh_r        <= '0;
      gc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nonempty_r  <= nonempty_nxt;
      gh_r        <= gh_nxt;
      gc_r        <= gc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r  <= tgt_nxt;
    push_r <= push_nxt;
    src_r  <= src_nxt;
    tag_r  <= tag_nxt;
    job_r  <= job_nxt;
    got_r  <= got_nxt;
    osrc_r <= osrc_nxt;
    vic_r  <= vic_nxt;
    st_r   <= st_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    nonempty_nxt  = nonempty_r;
    gh_nxt        = gh_r;
    gc_nxt        = gc_r;
    tgt_nxt       = tgt_r;
    push_nxt      = push_r;
    src_nxt       = src_r;
    tag_nxt       = tag_r;
    out_valid_nxt = 1'b0;
    job_nxt       = '0;
    got_nxt       = 1'b0;
    osrc_nxt      = SRC_NONE;
    vic_nxt       = '0;
    st_nxt        = ST_OK;
    g_we          = 1'b0;
    g_waddr       = GA'(gsum >= 32'(GLOBAL_DEPTH) ? gsum - 32'(GLOBAL_DEPTH) : gsum);
    g_re          = 1'b0;
    g_raddr       = gh_r;
    l_we          = 1'b0;
    l_waddr       = SA'(32'(tgt_r) * 32'(LOCAL_DEPTH) +
                        (lsum >= 32'(LOCAL_DEPTH) ? lsum - 32'(LOCAL_DEPTH) : lsum));
    l_re          = 1'b0;
    l_raddr       = SA'(32'(tgt_r) * 32'(LOCAL_DEPTH) + 32'(m_rhead));
    m_re          = 1'b0;
    m_raddr       = w_idx;
    m_we          = 1'b0;
    m_whead       = m_rhead;
    m_wcount      = m_rcount;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          tag_nxt       = in_job_tag;
          if (!en_r) begin
            st_nxt = ST_DISABLED;
          end else begin
            case (cmd_t'(in_cmd))
              CMD_SUBMIT_GLOBAL, CMD_SUBMIT_WORKER: begin
                if (cmd_t'(in_cmd) == CMD_SUBMIT_WORKER && w_ok) begin
                  // own queue: head/count come back next cycle
                  out_valid_nxt = 1'b0;
                  m_re          = 1'b1;
                  tgt_nxt       = w_idx;
                  push_nxt      = 1'b1;
                  state_nxt     = S_META;
                end else if (32'(gc_r) == 32'(GLOBAL_DEPTH)) begin
                  st_nxt = ST_FULL;
                end else begin
                  g_we   = 1'b1;
                  gc_nxt = gc_r + GCW'(1);
                  st_nxt = (cmd_t'(in_cmd) == CMD_SUBMIT_WORKER) ? ST_REDIRECT : ST_OK;
                end
              end
              CMD_FETCH: begin
                if (!w_ok) begin
                  st_nxt = ST_BAD_WORKER;
                end else if (nonempty_r[w_idx]) begin
                  out_valid_nxt = 1'b0;
                  m_re          = 1'b1;
                  tgt_nxt       = w_idx;
                  push_nxt      = 1'b0;
                  src_nxt       = SRC_OWN;
                  state_nxt     = S_META;
                end else if (gc_r != '0) begin
                  out_valid_nxt = 1'b0;
                  g_re          = 1'b1;
                  gh_nxt        = (32'(gh_r) + 32'd1 == 32'(GLOBAL_DEPTH)) ? '0
                                                                           : gh_r + GA'(1);
                  gc_nxt        = gc_r - GCW'(1);
                  state_nxt     = S_GDATA;
                end else if (steal_found) begin
                  out_valid_nxt = 1'b0;
                  m_re          = 1'b1;
                  m_raddr       = steal_victim;
                  tgt_nxt       = steal_victim;
                  push_nxt      = 1'b0;
                  src_nxt       = SRC_STOLEN;
                  state_nxt     = S_META;
                end
              end
              default: ;
            endcase
          end
        end
      end

      S_META: begin
        state_nxt = S_IDLE;
        if (push_r) begin
          out_valid_nxt = 1'b1;
          if (32'(m_rcount) == 32'(LOCAL_DEPTH)) begin
            st_nxt = ST_FULL;
          end else begin
            l_we                = 1'b1;
            m_we                = 1'b1;
            m_wcount            = m_rcount + LCW'(1);
            nonempty_nxt[tgt_r] = 1'b1;
          end
        end else begin
          // pop: queue known non-empty from its flag
          l_re                = 1'b1;
          m_we                = 1'b1;
          m_whead             = (32'(m_rhead) + 32'd1 == 32'(LOCAL_DEPTH)) ? '0
                                                                           : m_rhead + LA'(1);
          m_wcount            = m_rcount - LCW'(1);
          nonempty_nxt[tgt_r] = (m_rcount != LCW'(1));
          state_nxt           = S_LDATA;
        end
      end

      S_LDATA: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        job_nxt       = l_rdata;
        got_nxt       = 1'b1;
        osrc_nxt      = src_r;
        vic_nxt       = (src_r == SRC_STOLEN) ? VICTIM_BITS'(tgt_r) : '0;
      end

      S_GDATA: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        job_nxt       = g_rdata;
        got_nxt       = 1'b1;
        osrc_nxt      = SRC_GLOBAL;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_job_out = job_r;
  assign out_got_job = got_r;
  assign out_source  = osrc_r;
  assign out_victim  = vic_r;
  assign out_status  = st_r;

endmodule

`default_nettype wire

FILE: rtl/wsjd_checker.sv
// ----------------------------------------------------------------------------
// wsjd_checker
// Port-level checks on the dispatcher's result strobe and fields.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wsjd_checker import wsjd_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   busy,
  input wire logic                   out_valid,
  input wire logic [TAG_BITS-1:0]    out_job_out,
  input wire logic                   out_got_job,
  input wire logic [1:0]             out_source,
  input wire logic [VICTIM_BITS-1:0] out_victim
);

  `WSJD_ASSERT(a_got_matches_source, clk, rst_n, out_valid |-> (out_got_job == (out_source != SRC_NONE)), "got_job disagrees with source")
  `WSJD_ASSERT(a_victim_only_stolen, clk, rst_n, (out_valid && out_source != SRC_STOLEN) |-> (out_victim == '0), "victim set on a non-stolen item")
  `WSJD_ASSERT(a_no_job_zero_tag, clk, rst_n, (out_valid && !out_got_job) |-> (out_job_out == '0), "tag on an item without a job")
  `WSJD_ASSERT(a_busy_end_strobes, clk, rst_n, ($fell(busy) && $past(rst_n)) |-> out_valid, "busy ended without a result")
  `WSJD_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "result strobe after reset")

endmodule

bind work_stealing_job_dispatcher wsjd_checker u_wsjd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_job_out (out_job_out),
  .out_got_job (out_got_job),
  .out_source  (out_source),
  .out_victim  (out_victim)
);

`default_nettype wire
